// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// coordinate widths, command codes and the item record that moves along
// the row of edge cells
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W = 24;           // signed coordinate width
    localparam int DIFF_W  = COORD_W + 1;  // difference of two coordinates
    localparam int PROD_W  = 2 * DIFF_W;   // exact product of two differences
    localparam int IDX_W   = 4;            // vertex slot field width
    localparam int COUNT_W = 5;            // vertex count register width

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_TEST  = 1'b1
    } cmd_t;

    // one item in flight: the command, its coordinates and the running
    // state of a test (previous vertex, first vertex, parity so far)
    typedef struct packed
    {
        cmd_t                      cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic                      parity;
    } item_t;

endpackage

// File: rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd ray casting point-in-polygon test
// polygon of up to MAX_VERTICES vertices held in a row of edge cells
// ----------------------------------------------------------------------------
// Every item (vertex write or point test) enters the first cell and moves
// down a row of MAX_VERTICES cells plus one closing cell, so a new item can
// be taken in every cycle while not halted, and results leave in test order.
// Each cell keeps one vertex slot; a write is captured by the cell of its
// slot as it passes, so tests already ahead of it see the old vertex and
// tests behind it see the new one. A test carries the previous vertex and
// the first vertex along; cell k checks the edge from vertex k-1 to vertex
// k, and the closing cell checks the edge from the last vertex in use back
// to vertex 0. Each edge check is an exact cross-multiplied compare over
// three registers (differences, two 25x25 products, compare); a test result
// passes these in every cell and the closing cell, then the output
// register; a write gives no result. The chain halts only while a
// finished result waits on the output and another test has reached the end
// of the chain; otherwise new transfers are taken even while the output is
// stalled. vertex_count may only be written while no item is in flight;
// cfg_ready is always high. Slots below vertex_count must be written before
// a test reads them.
// ----------------------------------------------------------------------------
module point_in_polygon_test
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // item channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0] coord_y,

    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               inside_res,

    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pip_pkg::COUNT_W-1:0]        vertex_count
);

    logic [pip_pkg::COUNT_W-1:0] count_reg;

    // chain links: link k feeds cell k, link MAX_VERTICES feeds closing cell
    logic                        link_valid [MAX_VERTICES+1];
    pip_pkg::item_t              link_item  [MAX_VERTICES+1];

    logic                        last_valid;
    pip_pkg::item_t              last_item;
    logic                        last_test;
    logic                        close_on;
    logic                        en;

    logic                        out_valid_reg, out_valid_next;
    logic                        inside_reg, inside_next;

    // configuration register, write always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= vertex_count;
        end
    end

    // chain advances unless a test at the end would overwrite a held result
    assign last_test = last_valid && (last_item.cmd == pip_pkg::CMD_TEST);
    assign en        = !(out_valid_reg && out_stall && last_test);
    assign in_stall  = !en;

    // entering item: running state starts clear
    assign link_valid[0] = in_valid;
    assign link_item[0]  = '{cmd:    pip_pkg::cmd_t'(command),
                             idx:    vertex_index,
                             x:      coord_x,
                             y:      coord_y,
                             px:     '0,
                             py:     '0,
                             fx:     '0,
                             fy:     '0,
                             parity: 1'b0};

    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        pip_cell
        #(
            .INDEX (k)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .count     (count_reg),
            .in_valid  (link_valid[k]),
            .in_item   (link_item[k]),
            .out_valid (link_valid[k+1]),
            .out_item  (link_item[k+1])
        );
    end

    // closing edge: last vertex in use back to vertex 0; an empty polygon
    // checks nothing and answers outside
    assign close_on = link_valid[MAX_VERTICES]
                   && (link_item[MAX_VERTICES].cmd == pip_pkg::CMD_TEST)
                   && (count_reg != '0);

    pip_edge_eval u_close
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (link_valid[MAX_VERTICES]),
        .in_item   (link_item[MAX_VERTICES]),
        .edge_on   (close_on),
        .xi        (link_item[MAX_VERTICES].fx),
        .yi        (link_item[MAX_VERTICES].fy),
        .xj        (link_item[MAX_VERTICES].px),
        .yj        (link_item[MAX_VERTICES].py),
        .out_valid (last_valid),
        .out_item  (last_item)
    );

    // output register: tests land here, writes drop out of the chain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        inside_next    = inside_reg;
        if (en && last_test)
        begin
            out_valid_next = 1'b1;
            inside_next    = last_item.parity;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

endmodule

// File: rtl/pip_edge_eval.sv
// ----------------------------------------------------------------------------
// pip_edge_eval: three-register edge crossing check
// decides whether the ray from the item's point crosses edge j->i and
// toggles the item's parity bit; exact cross-multiplied compare
// ----------------------------------------------------------------------------
module pip_edge_eval
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  pip_pkg::item_t                     in_item,
    input  logic                               edge_on,
    input  logic signed [pip_pkg::COORD_W-1:0] xi,
    input  logic signed [pip_pkg::COORD_W-1:0] yi,
    input  logic signed [pip_pkg::COORD_W-1:0] xj,
    input  logic signed [pip_pkg::COORD_W-1:0] yj,
    output logic                               out_valid,
    output pip_pkg::item_t                     out_item
);

    // stage 1: differences and straddle
    logic                              v1_reg;
    pip_pkg::item_t                    item1_reg;
    logic                              hit1_reg, hit1_next;
    logic                              up1_reg, up1_next;
    logic signed [pip_pkg::DIFF_W-1:0] dxp_reg, dxp_next;
    logic signed [pip_pkg::DIFF_W-1:0] dye_reg, dye_next;
    logic signed [pip_pkg::DIFF_W-1:0] dxe_reg, dxe_next;
    logic signed [pip_pkg::DIFF_W-1:0] dyp_reg, dyp_next;

    // stage 2: products
    logic                              v2_reg;
    pip_pkg::item_t                    item2_reg;
    logic                              hit2_reg;
    logic                              up2_reg;
    logic signed [pip_pkg::PROD_W-1:0] p1_reg, p1_next;
    logic signed [pip_pkg::PROD_W-1:0] p2_reg, p2_next;

    // stage 3: compare and toggle
    logic                              v3_reg;
    pip_pkg::item_t                    item3_reg, item3_next;
    logic                              left;

    always_comb
    begin
        dxp_next  = {in_item.x[pip_pkg::COORD_W-1], in_item.x} - {xi[pip_pkg::COORD_W-1], xi};
        dyp_next  = {in_item.y[pip_pkg::COORD_W-1], in_item.y} - {yi[pip_pkg::COORD_W-1], yi};
        dxe_next  = {xj[pip_pkg::COORD_W-1], xj} - {xi[pip_pkg::COORD_W-1], xi};
        dye_next  = {yj[pip_pkg::COORD_W-1], yj} - {yi[pip_pkg::COORD_W-1], yi};
        // half-open on y: min <= y < max
        hit1_next = edge_on && (((yi <= in_item.y) && (in_item.y < yj))
                             || ((yj <= in_item.y) && (in_item.y < yi)));
        up1_next  = (yj > yi);
    end

    always_comb
    begin
        p1_next = pip_pkg::PROD_W'(dxp_reg) * pip_pkg::PROD_W'(dye_reg);
        p2_next = pip_pkg::PROD_W'(dxe_reg) * pip_pkg::PROD_W'(dyp_reg);
    end

    always_comb
    begin
        left       = up2_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg);
        item3_next = item2_reg;
        if (hit2_reg && left)
        begin
            item3_next.parity = !item2_reg.parity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= in_item;
            hit1_reg  <= hit1_next;
            up1_reg   <= up1_next;
            dxp_reg   <= dxp_next;
            dye_reg   <= dye_next;
            dxe_reg   <= dxe_next;
            dyp_reg   <= dyp_next;
            item2_reg <= item1_reg;
            hit2_reg  <= hit1_reg;
            up2_reg   <= up1_reg;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            item3_reg <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

// File: rtl/pip_cell.sv
// ----------------------------------------------------------------------------
// pip_cell: one vertex slot of the polygon chain
// holds vertex INDEX, captures writes to its slot as they pass, and checks
// the edge from the previous vertex to this one for passing tests
// ----------------------------------------------------------------------------
module pip_cell
#(
    parameter int INDEX = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [pip_pkg::COUNT_W-1:0]   count,
    input  logic                          in_valid,
    input  pip_pkg::item_t                in_item,
    output logic                          out_valid,
    output pip_pkg::item_t                out_item
);

    logic signed [pip_pkg::COORD_W-1:0] x_reg;
    logic signed [pip_pkg::COORD_W-1:0] y_reg;
    logic                               in_use;
    logic                               is_test;
    logic                               edge_on;
    pip_pkg::item_t                     mod_item;

    assign in_use  = (32'(count) > 32'(INDEX));
    assign is_test = in_valid && (in_item.cmd == pip_pkg::CMD_TEST);
    // slot zero has no edge of its own; the closing edge covers it
    assign edge_on = is_test && in_use && (INDEX != 0);

    always_comb
    begin
        mod_item = in_item;
        if (is_test && in_use)
        begin
            mod_item.px = x_reg;
            mod_item.py = y_reg;
            if (INDEX == 0)
            begin
                mod_item.fx = x_reg;
                mod_item.fy = y_reg;
            end
        end
    end

    // vertex slot, no reset: the user must keep unwritten slots from being read by a valid query; not enforced here
    always_ff @(posedge clk)
    begin
        if (en && in_valid && (in_item.cmd == pip_pkg::CMD_WRITE)
            && (32'(in_item.idx) == 32'(INDEX)))
        begin
            x_reg <= in_item.x;
            y_reg <= in_item.y;
        end
    end

    pip_edge_eval u_eval
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (mod_item),
        .edge_on   (edge_on),
        .xi        (x_reg),
        .yi        (y_reg),
        .xj        (in_item.px),
        .yj        (in_item.py),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

// File: dv/point_in_polygon_test_tb.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb: self-checking bench for the ray casting block
// drives vertex writes and point tests, predicts each inside flag from its
// own copy of the polygon and compares results in order as they come out
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

    localparam int MAX_V            = 16;
    // one test walks every edge cell plus the closing cell, three stages each
    localparam int PIPE_LATENCY     = 3 * (MAX_V + 1) + 1;
    localparam int SETTLE_CYCLES    = PIPE_LATENCY + 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int TESTS_PER_SESSION = 55;

    localparam logic signed [pip_pkg::COORD_W-1:0] COORD_MAX =
        {1'b0, {(pip_pkg::COORD_W-1){1'b1}}};
    localparam logic signed [pip_pkg::COORD_W-1:0] COORD_MIN =
        {1'b1, {(pip_pkg::COORD_W-1){1'b0}}};

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the polygon, predicted inside flags in order
    // ------------------------------------------------------------------------
    class pip_scoreboard;
        logic signed [pip_pkg::COORD_W-1:0] vert_x [MAX_V];
        logic signed [pip_pkg::COORD_W-1:0] vert_y [MAX_V];
        bit                                 vert_written [MAX_V];
        logic [pip_pkg::COUNT_W-1:0]        count_reg;
        bit                                 expected_inside [$];
        int                                 fail_count;
        int                                 result_count;

        function new();
            count_reg    = '0;
            fail_count   = 0;
            result_count = 0;
            foreach (vert_written[k])
            begin
                vert_written[k] = 1'b0;
            end
        endfunction

        function void set_count(logic [pip_pkg::COUNT_W-1:0] value);
            count_reg = value;
        endfunction

        // a count above the slot total acts as the slot total
        function int active_vertices();
            return (count_reg > MAX_V) ? MAX_V : int'(count_reg);
        endfunction

        // every slot in use has been written, so a test is legal
        function bit polygon_ready();
            for (int k = 0; k < active_vertices(); k++)
            begin
                if (!vert_written[k])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return expected_inside.size();
        endfunction

        // even-odd crossing count of a ray toward +x from the query point
        function bit ray_parity(logic signed [pip_pkg::COORD_W-1:0] qx,
                                logic signed [pip_pkg::COORD_W-1:0] qy);
            int     n;
            int     j;
            bit     parity;
            longint ax, ay, xi, yi, xj, yj, dy, lhs, rhs;
            n      = active_vertices();
            parity = 1'b0;
            ax     = qx;
            ay     = qy;
            j      = n - 1;
            for (int i = 0; i < n; i++)
            begin
                xi = vert_x[i];
                yi = vert_y[i];
                xj = vert_x[j];
                yj = vert_y[j];
                // half-open straddle, a horizontal edge never passes
                if ((yi <= ay && ay < yj) || (yj <= ay && ay < yi))
                begin
                    dy  = yj - yi;
                    lhs = (ax - xi) * dy;
                    rhs = (xj - xi) * (ay - yi);
                    // the crossing compare flips with the sign of dy
                    if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                        parity = ~parity;
                end
                j = i;
            end
            return parity;
        endfunction

        // an accepted transfer in: a write updates the polygon, a test
        // queues its predicted flag
        function void note_item(pip_pkg::cmd_t cmd, logic [pip_pkg::IDX_W-1:0] idx,
                                logic signed [pip_pkg::COORD_W-1:0] x,
                                logic signed [pip_pkg::COORD_W-1:0] y);
            if (cmd == pip_pkg::CMD_WRITE)
            begin
                if (idx < MAX_V)
                begin
                    vert_x[idx]       = x;
                    vert_y[idx]       = y;
                    vert_written[idx] = 1'b1;
                end
            end
            else
            begin
                expected_inside.push_back(ray_parity(x, y));
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        task check_result(logic got);
            bit want;
            if (expected_inside.size() == 0)
            begin
                report($sformatf("result with nothing expected, inside_res=%b", got));
                return;
            end
            want = expected_inside.pop_front();
            result_count++;
            if (got !== want)
                report($sformatf("result %0d inside_res=%b, predicted %b",
                                 result_count, got, want));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               in_valid     = 1'b0;
    logic                               in_stall;
    logic                               command      = pip_pkg::CMD_WRITE;
    logic [pip_pkg::IDX_W-1:0]          vertex_index = '0;
    logic signed [pip_pkg::COORD_W-1:0] coord_x      = '0;
    logic signed [pip_pkg::COORD_W-1:0] coord_y      = '0;
    logic                               out_valid;
    logic                               out_stall    = 1'b0;
    logic                               inside_res;
    logic                               cfg_valid    = 1'b0;
    logic                               cfg_ready;
    logic [pip_pkg::COUNT_W-1:0]        vertex_count = '0;

    pip_scoreboard sb = new();

    int send_idle_pct  = 0;  // chance per cycle that the sender holds off
    int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int cycle_count    = 0;

    int count_plan [16] = '{3, 31, 0, 5, 1, 16, 2, 9, 17, 4, 12, 6, 31, 3, 14, 7};
    int idle_plan  [4]  = '{0, 71, 0, 22};
    int stall_plan [4]  = '{0, 0, 71, 22};

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_V)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inside_res   (inside_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .vertex_count (vertex_count)
    );

    // 2 time unit clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver backpressure, changed on the falling edge only
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result side: a transfer out happens at a rising edge with valid and no stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(inside_res);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one item transfer; returns just after the accepting rising edge
    task automatic send_item(input pip_pkg::cmd_t cmd,
                             input logic [pip_pkg::IDX_W-1:0] idx,
                             input logic signed [pip_pkg::COORD_W-1:0] x,
                             input logic signed [pip_pkg::COORD_W-1:0] y);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        vertex_index <= idx;
        coord_x      <= x;
        coord_y      <= y;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(cmd, idx, x, y);
    endtask

    // the slot field of a test is don't-care, so it is random
    task automatic send_test(input logic signed [pip_pkg::COORD_W-1:0] x,
                             input logic signed [pip_pkg::COORD_W-1:0] y);
        send_item(pip_pkg::CMD_TEST, pip_pkg::IDX_W'($urandom_range(MAX_V - 1)), x, y);
    endtask

    // stop sending, wait for every predicted flag, then let writes flush
    task automatic drain(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // register write, only called with the chain empty
    task automatic write_count(input logic [pip_pkg::COUNT_W-1:0] value);
        @(negedge clk);
        cfg_valid    <= 1'b1;
        vertex_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_count(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [pip_pkg::COORD_W-1:0] near_coord(input int scale);
        int v;
        v = int'($urandom_range(2 * scale)) - scale;
        return v[pip_pkg::COORD_W-1:0];
    endfunction

    // one polygon: set the count, write the slots in use, then mostly tests
    // with a few stray writes and far-off points mixed in
    task automatic run_session(input int count, input bit hold_off);
        int                                 n_used;
        int                                 scale;
        int                                 r;
        int                                 k;
        logic signed [pip_pkg::COORD_W-1:0] vx;
        logic signed [pip_pkg::COORD_W-1:0] vy;
        logic signed [pip_pkg::COORD_W-1:0] prev_x;
        logic signed [pip_pkg::COORD_W-1:0] prev_y;
        drain(SETTLE_CYCLES);
        write_count(pip_pkg::COUNT_W'(count));
        n_used = (count > MAX_V) ? MAX_V : count;
        r      = $urandom_range(9);
        scale  = (r < 4) ? 255 : (r < 7) ? 65535 : (r < 9) ? 4000000 : int'(COORD_MAX);
        prev_x = '0;
        prev_y = '0;
        for (k = 0; k < n_used; k++)
        begin
            vx = near_coord(scale);
            vy = near_coord(scale);
            // horizontal and vertical edges now and then
            if (k > 0 && $urandom_range(5) == 0)
                vy = prev_y;
            else if (k > 0 && $urandom_range(7) == 0)
                vx = prev_x;
            send_item(pip_pkg::CMD_WRITE, pip_pkg::IDX_W'(k), vx, vy);
            prev_x = vx;
            prev_y = vy;
        end
        for (int t = 0; t < TESTS_PER_SESSION; t++)
        begin
            // at least once, let the whole chain empty out before going on
            if (hold_off && t == TESTS_PER_SESSION / 2)
                drain(0);
            r = $urandom_range(99);
            if (r < 8)
            begin
                // stray write, any slot, sometimes full-range coordinates
                if ($urandom_range(1))
                    send_item(pip_pkg::CMD_WRITE,
                              pip_pkg::IDX_W'($urandom_range(MAX_V - 1)),
                              pip_pkg::COORD_W'($urandom()),
                              pip_pkg::COORD_W'($urandom()));
                else
                    send_item(pip_pkg::CMD_WRITE,
                              pip_pkg::IDX_W'($urandom_range(MAX_V - 1)),
                              near_coord(scale), near_coord(scale));
            end
            else if (r < 16)
            begin
                send_test(pip_pkg::COORD_W'($urandom()), pip_pkg::COORD_W'($urandom()));
            end
            else if (r < 32 && n_used > 0)
            begin
                // point on a vertex row or column, hits the half-open edges
                k = $urandom_range(n_used - 1);
                if ($urandom_range(1))
                    send_test(near_coord(scale), sb.vert_y[k]);
                else
                    send_test(sb.vert_x[k], near_coord(scale));
            end
            else
            begin
                send_test(near_coord(scale), near_coord(scale));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, no idling on either side
        write_count(pip_pkg::COUNT_W'(0));
        // empty polygon answers outside, even at the coordinate extremes
        send_test(COORD_MAX, COORD_MAX);
        send_test(COORD_MIN, COORD_MIN);
        send_item(pip_pkg::CMD_WRITE, pip_pkg::IDX_W'(MAX_V - 1), COORD_MIN, COORD_MAX);

        // square: center, outside, left and right edges, horizontal edges, corner
        drain(SETTLE_CYCLES);
        write_count(pip_pkg::COUNT_W'(4));
        send_item(pip_pkg::CMD_WRITE, 4'd0, -24'sd100, -24'sd100);
        send_item(pip_pkg::CMD_WRITE, 4'd1,  24'sd100, -24'sd100);
        send_item(pip_pkg::CMD_WRITE, 4'd2,  24'sd100,  24'sd100);
        send_item(pip_pkg::CMD_WRITE, 4'd3, -24'sd100,  24'sd100);
        send_test(24'sd0, 24'sd0);
        send_test(24'sd200, 24'sd0);
        send_test(-24'sd100, 24'sd0);
        send_test(24'sd100, 24'sd0);
        send_test(24'sd0, -24'sd100);
        send_test(24'sd0, 24'sd100);
        send_test(-24'sd100, -24'sd100);

        // triangle spanning the whole coordinate range, widest products
        drain(SETTLE_CYCLES);
        write_count(pip_pkg::COUNT_W'(3));
        send_item(pip_pkg::CMD_WRITE, 4'd0, COORD_MIN, COORD_MIN);
        send_item(pip_pkg::CMD_WRITE, 4'd1, COORD_MAX, COORD_MIN);
        send_item(pip_pkg::CMD_WRITE, 4'd2, 24'sd0, COORD_MAX);
        send_test(24'sd0, 24'sd0);
        send_test(COORD_MIN, 24'sd0);
        send_test(-24'sd1, COORD_MAX - 24'sd1);

        // single vertex: only a degenerate edge
        drain(SETTLE_CYCLES);
        write_count(pip_pkg::COUNT_W'(1));
        send_test(COORD_MIN, COORD_MIN);

        // random part, four idling phases of four polygons each
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int s = 0; s < 4; s++)
                run_session(count_plan[4 * p + s], s == 1);
        end

        drain(SETTLE_CYCLES);
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
